>>> src/sdspi_pkg.sv
package sdspi_pkg;

    typedef logic [5:0] phase_t;

    // Sequencer steps. Codes named PH_ wait for a received byte; codes named
    // CN_ are decision points that are passed through within one item.
    localparam phase_t PH_IDLE        = 6'd0;
    localparam phase_t PH_SPIN        = 6'd1;
    localparam phase_t PH_CMD         = 6'd2;
    localparam phase_t PH_POLL        = 6'd3;
    localparam phase_t CN_INIT        = 6'd4;
    localparam phase_t CN_INIT_SEL    = 6'd5;
    localparam phase_t CN_RST_LOOP    = 6'd6;
    localparam phase_t CN_RST_RESP    = 6'd7;
    localparam phase_t CN_SDHC        = 6'd8;
    localparam phase_t CN_CMD8        = 6'd9;
    localparam phase_t CN_CMD8_RESP   = 6'd10;
    localparam phase_t PH_PUMP        = 6'd11;
    localparam phase_t PH_OCR_GO      = 6'd12;
    localparam phase_t CN_OUTER_LOOP  = 6'd13;
    localparam phase_t CN_V2_START    = 6'd14;
    localparam phase_t CN_V2_LOOP     = 6'd15;
    localparam phase_t CN_V2_55       = 6'd16;
    localparam phase_t PH_V2_41       = 6'd17;
    localparam phase_t CN_V2_41       = 6'd18;
    localparam phase_t PH_V2_OK       = 6'd19;
    localparam phase_t CN_V2_58       = 6'd20;
    localparam phase_t CN_OUTER_CHECK = 6'd21;
    localparam phase_t PH_OCR_BYTE    = 6'd22;
    localparam phase_t PH_OCR_TAIL    = 6'd23;
    localparam phase_t CN_V1_START    = 6'd24;
    localparam phase_t PH_V1_GO       = 6'd25;
    localparam phase_t CN_V1_LOOP     = 6'd26;
    localparam phase_t CN_V1_RESP     = 6'd27;
    localparam phase_t PH_V1_OK       = 6'd28;
    localparam phase_t CN_STD         = 6'd29;
    localparam phase_t CN_AFTER       = 6'd30;
    localparam phase_t CN_TAIL1       = 6'd31;
    localparam phase_t PH_TAIL2       = 6'd32;
    localparam phase_t PH_INIT_END    = 6'd33;
    localparam phase_t CN_READ        = 6'd34;
    localparam phase_t PH_R_SEL       = 6'd35;
    localparam phase_t PH_R_CMD       = 6'd36;
    localparam phase_t CN_R_RESP      = 6'd37;
    localparam phase_t CN_R_TLOOP     = 6'd38;
    localparam phase_t PH_R_TOK       = 6'd39;
    localparam phase_t PH_R_DATA      = 6'd40;
    localparam phase_t CN_R_FINAL     = 6'd41;
    localparam phase_t PH_R_END       = 6'd42;

    // Item kinds
    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_RX   = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_RESP_WAIT  = 3'd0;
    localparam logic [2:0] REG_TOKEN_WAIT = 3'd1;
    localparam logic [2:0] REG_SPIN       = 3'd2;
    localparam logic [2:0] REG_RESET_TRY  = 3'd3;
    localparam logic [2:0] REG_V1_TRY     = 3'd4;
    localparam logic [2:0] REG_V2_TRY     = 3'd5;
    localparam logic [2:0] REG_OCR_TRY    = 3'd6;

    // Register reset values
    localparam logic [15:0] RESP_WAIT_RST  = 16'd40000;
    localparam logic [20:0] TOKEN_WAIT_RST = 21'd1500000;
    localparam logic [7:0]  SPIN_RST       = 8'd200;
    localparam logic [3:0]  RESET_TRY_RST  = 4'd8;
    localparam logic [4:0]  V1_TRY_RST     = 5'd20;
    localparam logic [14:0] V2_TRY_RST     = 15'd20000;
    localparam logic [5:0]  OCR_TRY_RST    = 6'd50;

    // Command frames: bits 7:0 command byte, bits 23:16 CRC byte
    localparam logic [23:0] FRAME_CMD0  = 24'h950040;
    localparam logic [23:0] FRAME_CMD1  = 24'hFF0041;
    localparam logic [23:0] FRAME_CMD8  = 24'h870048;
    localparam logic [23:0] FRAME_CMD16 = 24'hFF0050;
    localparam logic [23:0] FRAME_CMD17 = 24'hFF0051;
    localparam logic [23:0] FRAME_CMD55 = 24'hFF0077;
    localparam logic [23:0] FRAME_CMD41 = 24'h870069;
    localparam logic [23:0] FRAME_CMD58 = 24'hFF007A;

    localparam logic [31:0] ARG_CMD8    = 32'h000001AA;
    localparam logic [31:0] ARG_CMD41   = 32'h40000000;
    localparam logic [31:0] ARG_CMD16   = 32'h00000001;
    localparam logic [15:0] CHECK_PAT   = 16'h01AA;
    localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
    localparam logic [7:0]  DATA_TOKEN  = 8'hFE;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [9:0]  SECTOR_LEN  = 10'd512;

    // Enough passes for the longest chain of decisions in one item
    localparam int CHAIN_PASSES = 10;

endpackage

>>> src/sd_card_spi_host_sequencer_unit.sv
// SD card SPI-mode host sequencer. Each accepted item (start init, start read
// with a block number, or the byte received on the last SPI transfer) yields
// exactly one result in the next cycle: the next byte to send if any, the
// chip-select and fast-clock levels, a sector data byte when one arrived, and
// done/status when an operation ends. One item is taken every clock; the whole
// decision chain for an item is settled combinationally between the input
// handshake and the result register, and a new item is taken whenever the
// result register is empty or being read. The user must set retry and wait
// limits by register port while idle (not enforced); cfg_ready is always high.
module sd_card_spi_host_sequencer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // item in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] block_address,
    input  logic [7:0]  rx_byte,
    // result out
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        chip_select,
    output logic        fast_clock,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic        data_last,
    output logic        done_res,
    output logic        status,
    output logic        high_capacity,
    // registers
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    // configuration registers
    logic [15:0] resp_wait_reg;
    logic [20:0] token_wait_reg;
    logic [7:0]  spin_bytes_reg;
    logic [3:0]  reset_try_reg;
    logic [4:0]  v1_try_reg;
    logic [14:0] v2_try_reg;
    logic [5:0]  ocr_try_reg;

    // sequencer state
    sdspi_pkg::phase_t phase_reg, phase_next;
    sdspi_pkg::phase_t spin_ret_reg, spin_ret_next;
    sdspi_pkg::phase_t cmd_ret_reg, cmd_ret_next;
    logic        block_reg, block_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] arg_reg, arg_next;
    logic [31:0] pat_reg, pat_next;
    logic [15:0] resp_cnt_reg, resp_cnt_next;
    logic [20:0] token_cnt_reg, token_cnt_next;
    logic [14:0] retry_reg, retry_next;
    logic [5:0]  outer_reg, outer_next;
    logic [7:0]  spin_cnt_reg, spin_cnt_next;
    logic [9:0]  data_cnt_reg, data_cnt_next;
    logic        read_ok_reg, read_ok_next;
    logic        cs_reg, cs_next;
    logic        fast_reg, fast_next;

    // result register
    logic        ov_reg;
    logic        txv_reg, txv_next;
    logic [7:0]  tx_reg, tx_next;
    logic        dv_reg, dv_next;
    logic [7:0]  db_reg, db_next;
    logic        dl_reg, dl_next;
    logic        done_reg, done_next;
    logic        st_reg, st_next;

    logic accept;

    assign in_ready  = !ov_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_wait_reg  <= sdspi_pkg::RESP_WAIT_RST;
            token_wait_reg <= sdspi_pkg::TOKEN_WAIT_RST;
            spin_bytes_reg <= sdspi_pkg::SPIN_RST;
            reset_try_reg  <= sdspi_pkg::RESET_TRY_RST;
            v1_try_reg     <= sdspi_pkg::V1_TRY_RST;
            v2_try_reg     <= sdspi_pkg::V2_TRY_RST;
            ocr_try_reg    <= sdspi_pkg::OCR_TRY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdspi_pkg::REG_RESP_WAIT:  resp_wait_reg  <= cfg_data[15:0];
                sdspi_pkg::REG_TOKEN_WAIT: token_wait_reg <= cfg_data;
                sdspi_pkg::REG_SPIN:       spin_bytes_reg <= cfg_data[7:0];
                sdspi_pkg::REG_RESET_TRY:  reset_try_reg  <= cfg_data[3:0];
                sdspi_pkg::REG_V1_TRY:     v1_try_reg     <= cfg_data[4:0];
                sdspi_pkg::REG_V2_TRY:     v2_try_reg     <= cfg_data[14:0];
                sdspi_pkg::REG_OCR_TRY:    ocr_try_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // decision chain for one item
    always_comb
    begin
        sdspi_pkg::phase_t c;
        logic        run;
        logic        cmd_req;
        logic [23:0] cmd_frame;
        logic [31:0] cmd_arg;
        sdspi_pkg::phase_t cmd_ret;
        logic        spin_req;
        sdspi_pkg::phase_t spin_ret;
        logic [7:0]  last_resp;

        phase_next     = phase_reg;
        spin_ret_next  = spin_ret_reg;
        cmd_ret_next   = cmd_ret_reg;
        block_next     = block_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        arg_next       = arg_reg;
        pat_next       = pat_reg;
        resp_cnt_next  = resp_cnt_reg;
        token_cnt_next = token_cnt_reg;
        retry_next     = retry_reg;
        outer_next     = outer_reg;
        spin_cnt_next  = spin_cnt_reg;
        data_cnt_next  = data_cnt_reg;
        read_ok_next   = read_ok_reg;
        cs_next        = cs_reg;
        fast_next      = fast_reg;
        txv_next  = 1'b0;
        tx_next   = 8'd0;
        dv_next   = 1'b0;
        db_next   = 8'd0;
        dl_next   = 1'b0;
        done_next = 1'b0;
        st_next   = 1'b0;
        last_resp = 8'd0;
        c         = sdspi_pkg::PH_IDLE;
        run       = 1'b0;

        if (kind == sdspi_pkg::KIND_INIT)
        begin
            c   = sdspi_pkg::CN_INIT;
            run = 1'b1;
        end
        else if (kind == sdspi_pkg::KIND_READ)
        begin
            pat_next = block_address;
            c        = sdspi_pkg::CN_READ;
            run      = 1'b1;
        end
        else if (kind == sdspi_pkg::KIND_RX && phase_reg != sdspi_pkg::PH_IDLE)
        begin
            c   = phase_reg;
            run = 1'b1;
        end

        for (int s = 0; s < sdspi_pkg::CHAIN_PASSES; s++)
        begin
            cmd_req   = 1'b0;
            cmd_frame = 24'd0;
            cmd_arg   = 32'd0;
            cmd_ret   = sdspi_pkg::PH_IDLE;
            spin_req  = 1'b0;
            spin_ret  = sdspi_pkg::PH_IDLE;
            if (run)
            begin
                case (c)
                    sdspi_pkg::PH_SPIN:
                    begin
                        spin_cnt_next = spin_cnt_next - 8'd1;
                        if (spin_cnt_next != 8'd0)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_SPIN; run = 1'b0;
                        end
                        else
                            c = spin_ret_next;
                    end
                    sdspi_pkg::PH_CMD:
                    begin
                        if (idx_next >= 3'd1 && idx_next < 3'd5)
                        begin
                            case (idx_next)
                                3'd1:    tx_next = arg_next[31:24];
                                3'd2:    tx_next = arg_next[23:16];
                                3'd3:    tx_next = arg_next[15:8];
                                default: tx_next = arg_next[7:0];
                            endcase
                            idx_next = idx_next + 3'd1;
                            txv_next = 1'b1;
                            phase_next = sdspi_pkg::PH_CMD; run = 1'b0;
                        end
                        else if (idx_next == 3'd5)
                        begin
                            idx_next = 3'd6;
                            txv_next = 1'b1; tx_next = crc_next;
                            phase_next = sdspi_pkg::PH_CMD; run = 1'b0;
                        end
                        else
                        begin
                            // CRC byte went out: start the response poll
                            resp_cnt_next = resp_wait_reg;
                            c = sdspi_pkg::PH_POLL;
                        end
                    end
                    sdspi_pkg::PH_POLL:
                    begin
                        resp_cnt_next = resp_cnt_next - 16'd1;
                        if (resp_cnt_next != 16'd0 && rx_byte == sdspi_pkg::IDLE_BYTE)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_POLL; run = 1'b0;
                        end
                        else
                        begin
                            last_resp = rx_byte;
                            c = cmd_ret_next;
                        end
                    end
                    sdspi_pkg::CN_INIT:
                    begin
                        block_next = 1'b1; cs_next = 1'b0; fast_next = 1'b0;
                        spin_req = 1'b1; spin_ret = sdspi_pkg::CN_INIT_SEL;
                    end
                    sdspi_pkg::CN_INIT_SEL:
                    begin
                        cs_next = 1'b1;
                        retry_next = {11'd0, reset_try_reg};
                        c = sdspi_pkg::CN_RST_LOOP;
                    end
                    sdspi_pkg::CN_RST_LOOP:
                    begin
                        retry_next = {11'd0, retry_next[3:0] - 4'd1};
                        if (retry_next == 15'd0)
                            c = sdspi_pkg::CN_SDHC;
                        else
                        begin
                            cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD0;
                            cmd_ret = sdspi_pkg::CN_RST_RESP;
                        end
                    end
                    sdspi_pkg::CN_RST_RESP:
                    begin
                        if (last_resp == sdspi_pkg::R1_IDLE)
                            retry_next = 15'd1;
                        if (retry_next == 15'd2)
                        begin
                            done_next = 1'b1; st_next = 1'b1;
                            phase_next = sdspi_pkg::PH_IDLE; run = 1'b0;
                        end
                        else
                            c = sdspi_pkg::CN_RST_LOOP;
                    end
                    sdspi_pkg::CN_SDHC:
                    begin
                        spin_req = 1'b1; spin_ret = sdspi_pkg::CN_CMD8;
                    end
                    sdspi_pkg::CN_CMD8:
                    begin
                        cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD8;
                        cmd_arg = sdspi_pkg::ARG_CMD8; cmd_ret = sdspi_pkg::CN_CMD8_RESP;
                    end
                    sdspi_pkg::CN_CMD8_RESP:
                    begin
                        if (last_resp != sdspi_pkg::R1_IDLE)
                            c = sdspi_pkg::CN_V1_START;
                        else
                        begin
                            data_cnt_next = 10'd0; pat_next = 32'd0;
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_PUMP; run = 1'b0;
                        end
                    end
                    sdspi_pkg::PH_PUMP:
                    begin
                        pat_next = {pat_next[23:0], rx_byte};
                        data_cnt_next = data_cnt_next + 10'd1;
                        if (data_cnt_next < 10'd4)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_PUMP; run = 1'b0;
                        end
                        else if (pat_next[15:0] != sdspi_pkg::CHECK_PAT)
                            c = sdspi_pkg::CN_V1_START;
                        else
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_OCR_GO; run = 1'b0;
                        end
                    end
                    sdspi_pkg::PH_OCR_GO:
                    begin
                        outer_next = ocr_try_reg;
                        c = sdspi_pkg::CN_OUTER_LOOP;
                    end
                    sdspi_pkg::CN_OUTER_LOOP:
                    begin
                        outer_next = outer_next - 6'd1;
                        // with no idle burst and a one-try inner loop every outer
                        // pass fails at once, so the loop drains to standard mode
                        if (outer_next == 6'd0 ||
                            (spin_bytes_reg == 8'd0 && v2_try_reg == 15'd1))
                            c = sdspi_pkg::CN_STD;
                        else
                            c = sdspi_pkg::CN_V2_START;
                    end
                    sdspi_pkg::CN_V2_START:
                    begin
                        retry_next = v2_try_reg;
                        spin_req = 1'b1; spin_ret = sdspi_pkg::CN_V2_LOOP;
                    end
                    sdspi_pkg::CN_V2_LOOP:
                    begin
                        retry_next = retry_next - 15'd1;
                        if (retry_next == 15'd0)
                            c = sdspi_pkg::CN_OUTER_CHECK;
                        else
                        begin
                            cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD55;
                            cmd_ret = sdspi_pkg::CN_V2_55;
                        end
                    end
                    sdspi_pkg::CN_V2_55:
                    begin
                        if (last_resp == sdspi_pkg::R1_IDLE)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_V2_41; run = 1'b0;
                        end
                        else
                            c = sdspi_pkg::CN_V2_LOOP;
                    end
                    sdspi_pkg::PH_V2_41:
                    begin
                        cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD41;
                        cmd_arg = sdspi_pkg::ARG_CMD41; cmd_ret = sdspi_pkg::CN_V2_41;
                    end
                    sdspi_pkg::CN_V2_41:
                    begin
                        if (last_resp == sdspi_pkg::R1_READY)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_V2_OK; run = 1'b0;
                        end
                        else
                        begin
                            spin_req = 1'b1; spin_ret = sdspi_pkg::CN_V2_LOOP;
                        end
                    end
                    sdspi_pkg::PH_V2_OK:
                    begin
                        cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD58;
                        cmd_ret = sdspi_pkg::CN_V2_58;
                    end
                    sdspi_pkg::CN_V2_58:
                    begin
                        if (last_resp == sdspi_pkg::R1_READY)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_OCR_BYTE; run = 1'b0;
                        end
                        else
                            c = sdspi_pkg::CN_OUTER_CHECK;
                    end
                    sdspi_pkg::CN_OUTER_CHECK:
                    begin
                        if (outer_next == 6'd2)
                            c = sdspi_pkg::CN_STD;
                        else
                            c = sdspi_pkg::CN_OUTER_LOOP;
                    end
                    sdspi_pkg::PH_OCR_BYTE:
                    begin
                        // capacity bit of the first OCR byte
                        block_next = rx_byte[6];
                        data_cnt_next = 10'd1;
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_OCR_TAIL; run = 1'b0;
                    end
                    sdspi_pkg::PH_OCR_TAIL:
                    begin
                        if (data_cnt_next < 10'd4)
                        begin
                            data_cnt_next = data_cnt_next + 10'd1;
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_OCR_TAIL; run = 1'b0;
                        end
                        else
                            c = sdspi_pkg::CN_AFTER;
                    end
                    sdspi_pkg::CN_V1_START:
                    begin
                        retry_next = {10'd0, v1_try_reg};
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_V1_GO; run = 1'b0;
                    end
                    sdspi_pkg::PH_V1_GO:
                        c = sdspi_pkg::CN_V1_LOOP;
                    sdspi_pkg::CN_V1_LOOP:
                    begin
                        retry_next = {10'd0, retry_next[4:0] - 5'd1};
                        if (retry_next == 15'd0)
                            c = sdspi_pkg::CN_STD;
                        else
                        begin
                            cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD1;
                            cmd_ret = sdspi_pkg::CN_V1_RESP;
                        end
                    end
                    sdspi_pkg::CN_V1_RESP:
                    begin
                        if (last_resp == sdspi_pkg::R1_READY)
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_V1_OK; run = 1'b0;
                        end
                        else
                        begin
                            spin_req = 1'b1; spin_ret = sdspi_pkg::CN_V1_LOOP;
                        end
                    end
                    sdspi_pkg::PH_V1_OK:
                        c = sdspi_pkg::CN_STD;
                    sdspi_pkg::CN_STD:
                    begin
                        block_next = 1'b0;
                        c = sdspi_pkg::CN_AFTER;
                    end
                    sdspi_pkg::CN_AFTER:
                    begin
                        if (block_next)
                            c = sdspi_pkg::CN_TAIL1;
                        else
                        begin
                            cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD16;
                            cmd_arg = sdspi_pkg::ARG_CMD16; cmd_ret = sdspi_pkg::CN_TAIL1;
                        end
                    end
                    sdspi_pkg::CN_TAIL1:
                    begin
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_TAIL2; run = 1'b0;
                    end
                    sdspi_pkg::PH_TAIL2:
                    begin
                        cs_next = 1'b0;
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_INIT_END; run = 1'b0;
                    end
                    sdspi_pkg::PH_INIT_END:
                    begin
                        done_next = 1'b1;
                        phase_next = sdspi_pkg::PH_IDLE; run = 1'b0;
                    end
                    sdspi_pkg::CN_READ:
                    begin
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_R_SEL; run = 1'b0;
                    end
                    sdspi_pkg::PH_R_SEL:
                    begin
                        cs_next = 1'b1; fast_next = 1'b1;
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_R_CMD; run = 1'b0;
                    end
                    sdspi_pkg::PH_R_CMD:
                    begin
                        cmd_req = 1'b1; cmd_frame = sdspi_pkg::FRAME_CMD17;
                        cmd_arg = pat_next; cmd_ret = sdspi_pkg::CN_R_RESP;
                    end
                    sdspi_pkg::CN_R_RESP:
                    begin
                        if (last_resp != sdspi_pkg::R1_READY)
                        begin
                            done_next = 1'b1; st_next = 1'b1;
                            phase_next = sdspi_pkg::PH_IDLE; run = 1'b0;
                        end
                        else
                        begin
                            token_cnt_next = token_wait_reg;
                            read_ok_next = 1'b0;
                            c = sdspi_pkg::CN_R_TLOOP;
                        end
                    end
                    sdspi_pkg::CN_R_TLOOP:
                    begin
                        token_cnt_next = token_cnt_next - 21'd1;
                        if (token_cnt_next == 21'd0)
                            c = sdspi_pkg::CN_R_FINAL;
                        else
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_R_TOK; run = 1'b0;
                        end
                    end
                    sdspi_pkg::PH_R_TOK:
                    begin
                        if (rx_byte == sdspi_pkg::DATA_TOKEN)
                        begin
                            data_cnt_next = 10'd0;
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_R_DATA; run = 1'b0;
                        end
                        else
                            c = sdspi_pkg::CN_R_TLOOP;
                    end
                    sdspi_pkg::PH_R_DATA:
                    begin
                        dv_next = 1'b1; db_next = rx_byte;
                        data_cnt_next = data_cnt_next + 10'd1;
                        if (data_cnt_next >= sdspi_pkg::SECTOR_LEN)
                        begin
                            dl_next = 1'b1; read_ok_next = 1'b1;
                            c = sdspi_pkg::CN_R_FINAL;
                        end
                        else
                        begin
                            txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                            phase_next = sdspi_pkg::PH_R_DATA; run = 1'b0;
                        end
                    end
                    sdspi_pkg::CN_R_FINAL:
                    begin
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_R_END; run = 1'b0;
                    end
                    sdspi_pkg::PH_R_END:
                    begin
                        cs_next = 1'b0; fast_next = 1'b0;
                        done_next = 1'b1; st_next = !read_ok_next;
                        phase_next = sdspi_pkg::PH_IDLE; run = 1'b0;
                    end
                    default:
                    begin
                        phase_next = sdspi_pkg::PH_IDLE; run = 1'b0;
                    end
                endcase

                // start of a command frame: command byte goes out now
                if (cmd_req)
                begin
                    crc_next = cmd_frame[23:16];
                    arg_next = block_next ? cmd_arg : {cmd_arg[22:0], 9'd0};
                    idx_next = 3'd1;
                    cmd_ret_next = cmd_ret;
                    txv_next = 1'b1; tx_next = cmd_frame[7:0];
                    phase_next = sdspi_pkg::PH_CMD; run = 1'b0;
                end

                // start of an idle burst, skipped when the burst length is zero
                if (spin_req)
                begin
                    spin_ret_next = spin_ret;
                    if (spin_bytes_reg == 8'd0)
                        c = spin_ret;
                    else
                    begin
                        spin_cnt_next = spin_bytes_reg;
                        txv_next = 1'b1; tx_next = sdspi_pkg::IDLE_BYTE;
                        phase_next = sdspi_pkg::PH_SPIN; run = 1'b0;
                    end
                end
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sdspi_pkg::PH_IDLE;
            spin_ret_reg  <= sdspi_pkg::PH_IDLE;
            cmd_ret_reg   <= sdspi_pkg::PH_IDLE;
            block_reg     <= 1'b1;
            idx_reg       <= 3'd0;
            resp_cnt_reg  <= 16'd0;
            token_cnt_reg <= 21'd0;
            retry_reg     <= 15'd0;
            outer_reg     <= 6'd0;
            spin_cnt_reg  <= 8'd0;
            data_cnt_reg  <= 10'd0;
            read_ok_reg   <= 1'b0;
            cs_reg        <= 1'b0;
            fast_reg      <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                spin_ret_reg  <= spin_ret_next;
                cmd_ret_reg   <= cmd_ret_next;
                block_reg     <= block_next;
                idx_reg       <= idx_next;
                resp_cnt_reg  <= resp_cnt_next;
                token_cnt_reg <= token_cnt_next;
                retry_reg     <= retry_next;
                outer_reg     <= outer_next;
                spin_cnt_reg  <= spin_cnt_next;
                data_cnt_reg  <= data_cnt_next;
                read_ok_reg   <= read_ok_next;
                cs_reg        <= cs_next;
                fast_reg      <= fast_next;
                ov_reg        <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            crc_reg  <= crc_next;
            arg_reg  <= arg_next;
            pat_reg  <= pat_next;
            txv_reg  <= txv_next;
            tx_reg   <= tx_next;
            dv_reg   <= dv_next;
            db_reg   <= db_next;
            dl_reg   <= dl_next;
            done_reg <= done_next;
            st_reg   <= st_next;
        end
    end

    assign out_valid     = ov_reg;
    assign tx_valid      = txv_reg;
    assign tx_byte       = tx_reg;
    assign chip_select   = cs_reg;
    assign fast_clock    = fast_reg;
    assign data_valid    = dv_reg;
    assign data_byte     = db_reg;
    assign data_last     = dl_reg;
    assign done_res      = done_reg;
    assign status        = st_reg;
    assign high_capacity = block_reg;

    // fast clock is only used with the card selected
    a_fast_needs_cs: assert property (@(posedge clk) disable iff (!rst_n)
        fast_reg |-> cs_reg)
        else $error("fast clock without chip select");

    // a finished operation leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && done_reg) |-> (phase_reg == sdspi_pkg::PH_IDLE))
        else $error("done reported while sequencer busy");

    // last sector byte comes with a data byte and moves the sequencer to PH_R_END
    a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && dl_reg) |-> (dv_reg && phase_reg == sdspi_pkg::PH_R_END))
        else $error("sector end without data byte");

    // sector byte count never passes one sector
    a_data_bound: assert property (@(posedge clk) disable iff (!rst_n)
        data_cnt_reg <= sdspi_pkg::SECTOR_LEN)
        else $error("sector byte count overrun");

endmodule
